FILE: design/ccg_pkg.sv
// shared types, constants and register codes for the crc codeword generator
package ccg_pkg;

   // field widths of the channels
   localparam int DATA_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int CW_W      = 39;
   localparam int CLEN_W    = 6;

   // generator limits: the codeword field holds at most a 32-bit generator
   localparam int MAX_GEN_BITS_DEF = 32;
   localparam int CW_LEN_CAP       = 32;
   localparam int LEN_MIN          = 2;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int GEN_BITS_W = 32;
   localparam int GEN_LEN_W  = 6;

   // register reset values
   localparam logic [GEN_BITS_W-1:0] GEN_BITS_RST = 32'd11;
   localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 6'd4;
   localparam logic                  MODE_RST     = 1'b1;

   // register indexes (byte address divided by four)
   typedef enum logic [1:0] {
      REG_GEN_BITS = 2'd0,
      REG_GEN_LEN  = 2'd1,
      REG_MODE     = 2'd2
   } ccg_reg_type;

   // dataword mode codes
   localparam logic MODE_NIBBLE = 1'b0;
   localparam logic MODE_BYTE   = 1'b1;

   // configuration seen by the datapath
   typedef struct packed {
      logic [GEN_BITS_W-1:0] gen_bits;
      logic [GEN_LEN_W-1:0]  gen_len;
      logic                  mode;
   } ccg_cfg_type;

endpackage

FILE: design/crc_codeword_generator_top.sv
// Programmable CRC codeword generator. Each accepted byte is held in an input
// register and runs through the division logic into a result register, from
// which its codeword transfers to the result channel. In eight-bit mode a byte
// gives one codeword and one byte is taken every cycle while the result
// channel does not stall. In four-bit mode a byte gives two codewords, high
// nibble first, both through the single encoder and result register, so a new
// byte is taken only as the low-nibble codeword of the byte before it moves on.
// The last codeword of a byte carries rsp_last_of_byte. Generator lengths outside
// 2 to min(MAX_GEN_BITS, 32) are clamped; change configuration only while idle.
module crc_codeword_generator_top import ccg_pkg::*; #(
   parameter int MAX_GEN_BITS = MAX_GEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_data_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CW_W-1:0]       rsp_codeword,
   output logic [CLEN_W-1:0]     rsp_codeword_length,
   output logic                  rsp_last_of_byte,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ccg_cfg_type       cfg;
   logic              in_vld_ff, in_vld_in;
   logic              in_phase_ff, in_phase_in;
   logic [DATA_W-1:0] in_byte_ff, in_byte_in;
   logic              out_vld_ff, out_vld_in;
   logic [CW_W-1:0]   out_cw_ff, out_cw_in;
   logic [CLEN_W-1:0] out_len_ff, out_len_in;
   logic              out_last_ff, out_last_in;
   logic [DATA_W-1:0] dword;
   logic              last_now;
   logic              out_free;
   logic              adv;
   logic              accept;
   logic [CW_W-1:0]   enc_cw;
   logic [CLEN_W-1:0] enc_len;

   ccg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // dataword select: whole byte, or high then low nibble
   always_comb begin
      if (cfg.mode == MODE_BYTE)
         dword = in_byte_ff;
      else if (in_phase_ff)
         dword = DATA_W'(in_byte_ff[NIBBLE_W-1:0]);
      else
         dword = DATA_W'(in_byte_ff[DATA_W-1:NIBBLE_W]);
   end

   assign last_now = (cfg.mode == MODE_BYTE) | in_phase_ff;

   ccg_encoder #(
      .MAX_GEN_BITS (MAX_GEN_BITS)
   ) u_encoder (
      .cfg             (cfg),
      .dword           (dword),
      .wide            (cfg.mode == MODE_BYTE),
      .codeword        (enc_cw),
      .codeword_length (enc_len)
   );

   // handshake and transfer control
   assign out_free  = ~out_vld_ff | ~rsp_stall;
   assign adv       = in_vld_ff & out_free;
   assign req_stall = in_vld_ff & ~(last_now & out_free);
   assign accept    = req_valid & ~req_stall;

   // input register
   always_comb begin
      in_vld_in   = in_vld_ff;
      in_phase_in = in_phase_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_vld_in   = 1'b1;
         in_phase_in = 1'b0;
         in_byte_in  = req_data_byte;
      end else if (adv & last_now) begin
         in_vld_in = 1'b0;
      end else if (adv) begin
         in_phase_in = 1'b1;
      end
   end

   // result register
   always_comb begin
      out_vld_in  = out_vld_ff & rsp_stall;
      out_cw_in   = out_cw_ff;
      out_len_in  = out_len_ff;
      out_last_in = out_last_ff;
      if (adv) begin
         out_vld_in  = 1'b1;
         out_cw_in   = enc_cw;
         out_len_in  = enc_len;
         out_last_in = last_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         in_phase_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         in_phase_ff <= in_phase_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      out_cw_ff   <= out_cw_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_codeword        = out_cw_ff;
   assign rsp_codeword_length = out_len_ff;
   assign rsp_last_of_byte    = out_last_ff;

`ifndef SYNTHESIS
   // first nibble moved on: the byte stays for its low nibble
   a_nibble_hold: assert property (@(posedge clock) disable iff (reset)
      adv && !last_now |=> in_vld_ff && in_phase_ff)
      else $error("input register lost byte after first nibble");

   // last codeword moved on with no new transfer: input register empties
   a_byte_done: assert property (@(posedge clock) disable iff (reset)
      adv && last_now && !accept |=> !in_vld_ff)
      else $error("input register kept a finished byte");

   // no new byte while the current one still has a codeword to give
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !(last_now && out_free) |-> req_stall)
      else $error("input accepted over a pending byte");

   // a delivered result always carries a legal length
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_codeword_length >= CLEN_W'(5) && rsp_codeword_length <= CLEN_W'(CW_W))
      else $error("codeword length out of range");
`endif

endmodule

FILE: design/ccg_csr.sv
// configuration registers behind an apb-style port
module ccg_csr import ccg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output ccg_cfg_type           cfg
);

   logic [GEN_BITS_W-1:0] gen_bits_ff, gen_bits_in;
   logic [GEN_LEN_W-1:0]  gen_len_ff, gen_len_in;
   logic                  mode_ff, mode_in;
   logic                  wr_en;
   ccg_reg_type           reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = ccg_reg_type'(paddr[CSR_ADDR_W-1:2]);

   // register write decode
   always_comb begin
      gen_bits_in = gen_bits_ff;
      gen_len_in  = gen_len_ff;
      mode_in     = mode_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_GEN_BITS: gen_bits_in = pwdata[GEN_BITS_W-1:0];
            REG_GEN_LEN:  gen_len_in  = pwdata[GEN_LEN_W-1:0];
            REG_MODE:     mode_in     = pwdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_bits_ff <= GEN_BITS_RST;
         gen_len_ff  <= GEN_LEN_RST;
         mode_ff     <= MODE_RST;
      end else begin
         gen_bits_ff <= gen_bits_in;
         gen_len_ff  <= gen_len_in;
         mode_ff     <= mode_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_GEN_BITS: prdata = CSR_DATA_W'(gen_bits_ff);
         REG_GEN_LEN:  prdata = CSR_DATA_W'(gen_len_ff);
         REG_MODE:     prdata = CSR_DATA_W'(mode_ff);
         default:      prdata = '0;
      endcase
   end

   assign cfg.gen_bits = gen_bits_ff;
   assign cfg.gen_len  = gen_len_ff;
   assign cfg.mode     = mode_ff;

endmodule

FILE: design/ccg_encoder.sv
// one dataword through the programmable crc division, left-aligned remainder form
module ccg_encoder import ccg_pkg::*; #(
   parameter int MAX_GEN_BITS = MAX_GEN_BITS_DEF
) (
   input  ccg_cfg_type       cfg,
   input  logic [DATA_W-1:0] dword,
   input  logic              wide,
   output logic [CW_W-1:0]   codeword,
   output logic [CLEN_W-1:0] codeword_length
);

   localparam int LEN_MAX = (MAX_GEN_BITS > CW_LEN_CAP) ? CW_LEN_CAP : MAX_GEN_BITS;
   localparam int REM_W   = LEN_MAX - 1;

   logic [GEN_LEN_W-1:0] eff_len;
   logic [GEN_LEN_W-1:0] align_sh;
   logic [REM_W-1:0]     gen_align;
   logic [REM_W-1:0]     rem_acc;
   logic [REM_W-1:0]     rem_out;
   logic                 fb;
   logic [CLEN_W-1:0]    dbits;

   // clamp the generator length to the supported range
   always_comb begin
      eff_len = cfg.gen_len;
      if (cfg.gen_len < GEN_LEN_W'(LEN_MIN))
         eff_len = GEN_LEN_W'(LEN_MIN);
      else if (cfg.gen_len > GEN_LEN_W'(LEN_MAX))
         eff_len = GEN_LEN_W'(LEN_MAX);
   end

   // generator without its top coefficient, aligned to the register msb
   assign align_sh  = GEN_LEN_W'(LEN_MAX) - eff_len;
   assign gen_align = cfg.gen_bits[REM_W-1:0] << align_sh;

   // msb-first division, leading zeros of a nibble leave the remainder at zero
   always_comb begin
      rem_acc = '0;
      fb      = 1'b0;
      for (int i = DATA_W - 1; i >= 0; i--) begin
         fb      = dword[i] ^ rem_acc[REM_W-1];
         rem_acc = (rem_acc << 1) ^ ({REM_W{fb}} & gen_align);
      end
   end

   assign rem_out = rem_acc >> align_sh;

   // assemble dataword and remainder
   assign dbits           = wide ? CLEN_W'(DATA_W) : CLEN_W'(NIBBLE_W);
   assign codeword        = (CW_W'(dword) << (eff_len - GEN_LEN_W'(1))) | CW_W'(rem_out);
   assign codeword_length = dbits + CLEN_W'(eff_len) - CLEN_W'(1);

endmodule
